[rtl/krt_pkg.sv]
// ----------------------------------------------------------------------------
// Keyed record table package
// Shared types, sizes and codes for the keyed record table and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package krt_pkg;

  // Table sizes.
  localparam int Capacity     = 16;
  localparam int PayloadWidth = 64;
  localparam int CntW         = $clog2(Capacity + 1);

  typedef logic [31:0]             key_t;
  typedef logic [PayloadWidth-1:0] pay_t;
  typedef logic [CntW-1:0]         cnt_t;

  // Command codes; anything above count behaves as count.
  typedef enum logic [2:0] {
    CmdAdd    = 3'd0,
    CmdGet    = 3'd1,
    CmdModify = 3'd2,
    CmdDelete = 3'd3,
    CmdCount  = 3'd4
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StPresent = 2'd1,
    StMissing = 2'd2,
    StFull    = 2'd3
  } status_e;

  // Update strobes broadcast to every cell during the execute cycle.
  typedef struct packed {
    logic add_en;
    logic mod_en;
    logic del_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/krt_cell.sv]
// ----------------------------------------------------------------------------
// Keyed record table cell
// One table slot: compares its key, passes hit and payload down the chain,
// and shifts in from its upper neighbor when it or a lower entry is deleted.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_cell (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire krt_pkg::cell_ctrl_t ctrl_i,
  input  wire krt_pkg::key_t       key_i,
  input  wire krt_pkg::pay_t       pay_i,
  // Chain from the lower neighbor.
  input  wire                      prev_occ_i,
  input  wire                      hit_i,
  input  wire krt_pkg::pay_t       fnd_i,
  // Contents of the upper neighbor.
  input  wire                      nxt_occ_i,
  input  wire krt_pkg::key_t       nxt_key_i,
  input  wire krt_pkg::pay_t       nxt_pay_i,
  // Chain to the upper neighbor.
  output logic                     occ_o,
  output krt_pkg::key_t            key_o,
  output krt_pkg::pay_t            pay_o,
  output logic                     hit_o,
  output krt_pkg::pay_t            fnd_o
);
  import krt_pkg::*;

  logic occ_q, occ_d;
  key_t key_q, key_d;
  pay_t pay_q, pay_d;
  logic match;

  // Key compare and hit / payload forwarding.
  assign match = occ_q && (key_q == key_i);
  assign hit_o = hit_i | match;
  assign fnd_o = fnd_i | (match ? pay_q : '0);

  // Slot update: delete shifts down, modify rewrites, add fills first free slot.
  always_comb begin
    occ_d = occ_q;
    key_d = key_q;
    pay_d = pay_q;
    if (ctrl_i.del_en && hit_o) begin
      occ_d = nxt_occ_i;
      key_d = nxt_key_i;
      pay_d = nxt_pay_i;
    end else if (ctrl_i.mod_en && match) begin
      pay_d = pay_i;
    end else if (ctrl_i.add_en && !occ_q && prev_occ_i) begin
      occ_d = 1'b1;
      key_d = key_i;
      pay_d = pay_i;
    end
  end

  // Occupancy flag is control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Stored key and payload.
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign occ_o = occ_q;
  assign key_o = key_q;
  assign pay_o = pay_q;

endmodule

`default_nettype wire

[rtl/keyed_record_table.sv]
// ----------------------------------------------------------------------------
// Keyed record table
// Ordered table of unique keys with payloads, built as a chain of cells.
// ----------------------------------------------------------------------------
//
//   Channel | Signals                                   | Direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, command_i, key_i, | in
//           | record_payload_i                          |
//   out     | out_valid_o, out_stall_i, status_o,       | out
//           | found_payload_o, entry_total_o            |
//
// Each transaction has two steps: the command is registered, then the
// compare, forward and shift pass runs along the cell chain. A new command
// is taken while the previous result waits in the output register; the
// execute cycle holds only if that register is still full and stalled.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_record_table (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [2:0]  command_i,
  input  wire  [31:0] key_i,
  input  wire  [63:0] record_payload_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  status_o,
  output logic [63:0] found_payload_o,
  output logic [4:0]  entry_total_o
);
  import krt_pkg::*;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StExec = 2'b10
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] cmd_q;
  key_t       key_q;
  pay_t       pay_q;
  cnt_t       cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic [1:0] status_q, status_d;
  logic [63:0] found_q, found_d;

  logic       in_acc, exec_go, any_hit, full;
  cell_ctrl_t ctrl;

  // Chain nets; index Capacity is the open end above the top cell.
  logic occ_w [0:Capacity];
  key_t key_w [0:Capacity];
  pay_t pay_w [0:Capacity];
  logic hit_w [0:Capacity];
  pay_t fnd_w [0:Capacity];

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign exec_go    = (state_q == StExec) && (!out_valid_q || !out_stall_i);
  assign full       = (cnt_q == CntW'(Capacity));

  // Cell chain.
  assign hit_w[0]        = 1'b0;
  assign fnd_w[0]        = '0;
  assign occ_w[Capacity] = 1'b0;
  assign key_w[Capacity] = '0;
  assign pay_w[Capacity] = '0;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic prev_occ;
    if (i == 0) begin : g_first
      assign prev_occ = 1'b1;
    end else begin : g_rest
      assign prev_occ = occ_w[i-1];
    end
    krt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .key_i      (key_q),
      .pay_i      (pay_q),
      .prev_occ_i (prev_occ),
      .hit_i      (hit_w[i]),
      .fnd_i      (fnd_w[i]),
      .nxt_occ_i  (occ_w[i+1]),
      .nxt_key_i  (key_w[i+1]),
      .nxt_pay_i  (pay_w[i+1]),
      .occ_o      (occ_w[i]),
      .key_o      (key_w[i]),
      .pay_o      (pay_w[i]),
      .hit_o      (hit_w[i+1]),
      .fnd_o      (fnd_w[i+1])
    );
  end

  assign any_hit = hit_w[Capacity];

  // Command decode, result and count update.
  always_comb begin
    ctrl        = '0;
    cnt_d       = cnt_q;
    status_d    = status_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (exec_go) begin
      out_valid_d = 1'b1;
      status_d    = StOk;
      found_d     = '0;
      case (cmd_q)
        CmdAdd: begin
          if (any_hit) begin
            status_d = StPresent;
          end else if (full) begin
            status_d = StFull;
          end else begin
            ctrl.add_en = 1'b1;
            cnt_d       = cnt_q + CntW'(1);
          end
        end
        CmdGet: begin
          if (!any_hit) begin
            status_d = StMissing;
          end else begin
            found_d = 64'(fnd_w[Capacity]);
          end
        end
        CmdModify: begin
          if (!any_hit) begin
            status_d = StMissing;
          end else begin
            ctrl.mod_en = 1'b1;
          end
        end
        CmdDelete: begin
          if (!any_hit) begin
            status_d = StMissing;
          end else begin
            ctrl.del_en = 1'b1;
            cnt_d       = cnt_q - CntW'(1);
          end
        end
        default: begin
          status_d = StOk;
        end
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (exec_go) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= command_i;
      key_q <= key_i;
      pay_q <= record_payload_i[PayloadWidth-1:0];
    end
    status_q <= status_d;
    found_q  <= found_d;
  end

  // Count after the command is the next count, latched with the result.
  logic [4:0] total_q;
  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      total_q <= 5'(cnt_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign found_payload_o = found_q;
  assign entry_total_o   = total_q;

endmodule

`default_nettype wire
